/* hw/rtl/spvg_pkg.sv */
// Shared types, constants and tables of the star polygon vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package spvg_pkg;

	localparam int MAX_SIDES = 1024;
	localparam int N_W = $clog2(MAX_SIDES + 1);
	localparam int REM_W = N_W + 1;
	localparam int IDX_W = 10;
	localparam int PHASE_W = 32;
	localparam int DIV_STEPS = IDX_W + PHASE_W;
	localparam int DIV_PER_STAGE = 6;
	localparam int DIV_STAGES = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
	localparam int CORDIC_STEPS = 30;
	localparam int XY_W = 34;
	localparam int Z_W = 34;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int RESULT_DEPTH = 4;
	localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic [16:0] LCG_MUL = 17'd69069;
	localparam logic KIND_INNER = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIDE_COUNT    = 3'd0,
		REG_CENTER_X      = 3'd1,
		REG_CENTER_Y      = 3'd2,
		REG_OUTER_RADIUS  = 3'd3,
		REG_INNER_RADIUS  = 3'd4,
		REG_OUTER_ANGLE   = 3'd5,
		REG_INNER_ANGLE   = 3'd6,
		REG_JITTER_AMOUNT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              vertex_kind;
		logic [IDX_W-1:0]  vertex_index;
		logic              apply_jitter;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} point_t;

	typedef struct packed {
		logic [10:0]        side_count;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [30:0]        outer_radius;
		logic [30:0]        inner_radius;
		logic [15:0]        outer_angle;
		logic [15:0]        inner_angle;
		logic signed [15:0] jitter_amount;
	} cfg_t;

	// One classified vertex request waiting for the arithmetic pipeline.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [N_W-1:0]   n;
		logic [15:0]      base;
		logic [30:0]      radius;
		logic             jit;
	} job_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/spvg_front.sv */
// Front end: classifies a vertex request against the configuration.
`timescale 1ns / 1ps
`default_nettype none
module spvg_front (
	input  spvg_pkg::vertex_t vertex,
	input  spvg_pkg::cfg_t    cfg,
	output spvg_pkg::job_t    job
);

	always_comb begin
		job.idx = vertex.vertex_index;
		if (cfg.side_count < 11'd2) begin
			job.n = spvg_pkg::N_W'(2);
		end else if (int'(cfg.side_count) > spvg_pkg::MAX_SIDES) begin
			job.n = spvg_pkg::N_W'(spvg_pkg::MAX_SIDES);
		end else begin
			job.n = spvg_pkg::N_W'(cfg.side_count);
		end
		if (vertex.vertex_kind == spvg_pkg::KIND_INNER) begin
			job.base   = cfg.inner_angle;
			job.radius = cfg.inner_radius;
		end else begin
			job.base   = cfg.outer_angle;
			job.radius = cfg.outer_radius;
		end
		// Jitter is only worth doing when the strength is nonzero.
		job.jit = vertex.apply_jitter && (cfg.jitter_amount != 16'sd0);
	end

endmodule
`default_nettype wire

/* hw/rtl/spvg_queue.sv */
// Short queue of classified requests between front end and pipeline.
`timescale 1ns / 1ps
`default_nettype none
module spvg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  spvg_pkg::job_t wr_data,
	input  logic           rd,
	output spvg_pkg::job_t rd_data,
	output logic           empty,
	output logic           full
);

	spvg_pkg::job_t                     mem_q [spvg_pkg::QUEUE_DEPTH];
	logic [spvg_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [spvg_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [spvg_pkg::QUEUE_PTR_W:0]     count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (spvg_pkg::QUEUE_PTR_W + 1)'(spvg_pkg::QUEUE_DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

/* hw/rtl/spvg_result_queue.sv */
// Output queue of finished vertex coordinates.
`timescale 1ns / 1ps
`default_nettype none
module spvg_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  spvg_pkg::point_t wr_data,
	input  logic             rd,
	output spvg_pkg::point_t rd_data,
	output logic             empty,
	output logic             full
);

	spvg_pkg::point_t                   mem_q [spvg_pkg::RESULT_DEPTH];
	logic [spvg_pkg::RESULT_PTR_W-1:0]  wr_ptr_q;
	logic [spvg_pkg::RESULT_PTR_W-1:0]  rd_ptr_q;
	logic [spvg_pkg::RESULT_PTR_W:0]    count_q;
	logic                               rd_ok;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (spvg_pkg::RESULT_PTR_W + 1)'(spvg_pkg::RESULT_DEPTH));
	assign rd_data = mem_q[rd_ptr_q];
	assign rd_ok   = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd_ok) begin
				count_q <= count_q + 1'b1;
			end else if (rd_ok && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

/* hw/rtl/spvg_back.sv */
// Back end: divider, CORDIC, scaling, jitter and saturation pipeline.
`timescale 1ns / 1ps
`default_nettype none
module spvg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  spvg_pkg::cfg_t   cfg,
	input  spvg_pkg::job_t   job,
	input  logic             job_valid,
	output logic             job_take,
	input  logic             room,
	output logic             res_valid,
	output spvg_pkg::point_t res
);

	localparam int STAGES  = spvg_pkg::DIV_STAGES + 1 + spvg_pkg::CORDIC_STEPS + 9;
	localparam int PROD_W  = 32 + spvg_pkg::XY_W;
	localparam int RND_W   = PROD_W - 30;
	localparam int PX_W    = RND_W + 1;
	localparam int T_W     = 49;
	localparam int PA_W    = T_W + 16;
	localparam int PB_W    = T_W + 17;
	localparam int OFF_W   = 36;
	localparam int FIN_W   = PX_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 29;
	localparam logic signed [FIN_W-1:0]  SAT_HI = FIN_W'(32'h7FFF_FFFF);
	localparam logic signed [FIN_W-1:0]  SAT_LO = -SAT_HI - FIN_W'(1);

	typedef struct packed {
		logic [spvg_pkg::IDX_W-1:0] idx;
		logic [spvg_pkg::N_W-1:0]   n;
		logic [15:0]                base;
		logic [30:0]                radius;
		logic                       jit;
		logic [spvg_pkg::REM_W-1:0] rem;
		logic [31:0]                quo;
	} div_t;

	typedef struct packed {
		logic signed [spvg_pkg::XY_W-1:0] x;
		logic signed [spvg_pkg::XY_W-1:0] y;
		logic signed [spvg_pkg::Z_W-1:0]  z;
		logic [1:0]                       qd;
		logic [30:0]                      radius;
		logic                             jit;
	} cor_t;

	// Several restoring division steps; the index bits shift in first, then zeros.
	function automatic div_t div_run(input div_t d, input int first);
		div_t                       r;
		logic                       bitv;
		logic [spvg_pkg::REM_W-1:0] sh;
		r = d;
		for (int k = 0; k < spvg_pkg::DIV_PER_STAGE; k++) begin
			if (first + k < spvg_pkg::DIV_STEPS) begin
				bitv  = r.idx[spvg_pkg::IDX_W-1];
				r.idx = {r.idx[spvg_pkg::IDX_W-2:0], 1'b0};
				sh    = {r.rem[spvg_pkg::REM_W-2:0], bitv};
				if (sh >= spvg_pkg::REM_W'(r.n)) begin
					r.rem = sh - spvg_pkg::REM_W'(r.n);
					r.quo = {r.quo[30:0], 1'b1};
				end else begin
					r.rem = sh;
					r.quo = {r.quo[30:0], 1'b0};
				end
			end
		end
		return r;
	endfunction

	function automatic cor_t cor_run(input cor_t c, input int i);
		cor_t                             r;
		logic signed [spvg_pkg::XY_W-1:0] dx;
		logic signed [spvg_pkg::XY_W-1:0] dy;
		logic signed [spvg_pkg::Z_W-1:0]  at;
		r  = c;
		dx = c.y >>> i;
		dy = c.x >>> i;
		at = spvg_pkg::Z_W'(spvg_pkg::atan_turn(i));
		if (c.z >= 0) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - at;
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + at;
		end
		return r;
	endfunction

	// Sum of two truncating remainders of the scaled coordinate.
	function automatic logic signed [11:0] hash_part(input logic signed [PX_W-1:0] v);
		logic               neg;
		logic signed [11:0] a;
		logic signed [11:0] b;
		neg = v[PX_W-1];
		a   = {2'b00, v[19:10]};
		b   = {6'b000000, v[11:6]};
		if (neg && (v[19:10] != 10'd0)) a = a - 12'sd1024;
		if (neg && (v[11:6] != 6'd0)) b = b - 12'sd64;
		return a + b;
	endfunction

	logic              adv;
	logic [STAGES-1:0] vld_q;
	logic signed [T_W-1:0] t_q;
	logic [30:0]           rmax;

	div_t div_s [spvg_pkg::DIV_STAGES];
	div_t div_in;
	cor_t cor_s [spvg_pkg::CORDIC_STEPS];
	cor_t ph_s;
	cor_t ph_in;
	logic [31:0] ph;
	logic [1:0]  qd;

	logic signed [spvg_pkg::XY_W-1:0] cx_s39, sy_s39;
	logic [30:0]                      rad_s39;
	logic                             jit_s39;
	logic signed [PROD_W-1:0]         prx_s40, pry_s40;
	logic                             jit_s40;
	logic signed [PROD_W-1:0]         sumx, sumy;
	logic signed [RND_W-1:0]          rx_s41, ry_s41;
	logic                             jit_s41;
	logic signed [PX_W-1:0]           px_s42, py_s42;
	logic                             jit_s42;
	logic signed [PX_W-1:0]           px_s43, py_s43;
	logic [31:0]                      seed_s43;
	logic                             jit_s43;
	logic signed [11:0]               hx, hy;
	logic signed [PX_W-1:0]           px_s44, py_s44;
	logic [31:0]                      l1_s44;
	logic                             jit_s44;
	logic signed [PX_W-1:0]           px_s45, py_s45;
	logic [31:0]                      l1_s45, l2_s45;
	logic                             jit_s45;
	logic signed [PX_W-1:0]           px_s46, py_s46;
	logic signed [PA_W-1:0]           pax_s46, pay_s46;
	logic signed [PB_W-1:0]           pbx_s46, pby_s46;
	logic                             jit_s46;
	logic signed [31:0]               d1, d2;
	logic signed [PB_W-1:0]           ofx_sum, ofy_sum;
	logic signed [PX_W-1:0]           px_s47, py_s47;
	logic signed [OFF_W-1:0]          ox_s47, oy_s47;
	logic signed [FIN_W-1:0]          fx, fy;

	// The whole pipeline moves together whenever the result queue can take an item.
	assign adv       = room;
	assign job_take  = adv && job_valid;
	assign res_valid = adv && vld_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], job_take};
		end
	end

	// Jitter scale depends on configuration only.
	assign rmax = (cfg.outer_radius > cfg.inner_radius) ? cfg.outer_radius : cfg.inner_radius;
	always_ff @(posedge clk) begin
		t_q <= T_W'(cfg.jitter_amount * $signed({1'b0, rmax, 1'b0}));
	end

	always_comb begin
		div_in.idx    = job.idx;
		div_in.n      = job.n;
		div_in.base   = job.base;
		div_in.radius = job.radius;
		div_in.jit    = job.jit;
		div_in.rem    = '0;
		div_in.quo    = '0;
	end

	for (genvar g = 0; g < spvg_pkg::DIV_STAGES; g++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				if (g == 0) begin
					div_s[g] <= div_run(div_in, 0);
				end else begin
					div_s[g] <= div_run(div_s[g == 0 ? 0 : g - 1], g * spvg_pkg::DIV_PER_STAGE);
				end
			end
		end
	end

	// Phase and reduction to the nearest quadrant.
	always_comb begin
		ph           = {div_s[spvg_pkg::DIV_STAGES-1].base, 16'h0000}
		             + div_s[spvg_pkg::DIV_STAGES-1].quo;
		qd           = ph[31:30] + {1'b0, ph[29]};
		ph_in.x      = spvg_pkg::CORDIC_GAIN;
		ph_in.y      = '0;
		ph_in.z      = spvg_pkg::Z_W'($signed({ph[31:30] - qd, ph[29:0]}));
		ph_in.qd     = qd;
		ph_in.radius = div_s[spvg_pkg::DIV_STAGES-1].radius;
		ph_in.jit    = div_s[spvg_pkg::DIV_STAGES-1].jit;
	end

	always_ff @(posedge clk) begin
		if (adv) ph_s <= ph_in;
	end

	for (genvar g = 0; g < spvg_pkg::CORDIC_STEPS; g++) begin : g_cor
		always_ff @(posedge clk) begin
			if (adv) begin
				if (g == 0) begin
					cor_s[g] <= cor_run(ph_s, 0);
				end else begin
					cor_s[g] <= cor_run(cor_s[g == 0 ? 0 : g - 1], g);
				end
			end
		end
	end

	always_comb begin
		sumx = prx_s40 + ROUND_HALF;
		sumy = pry_s40 + ROUND_HALF;
		hx   = hash_part(px_s42);
		hy   = hash_part(py_s42);
		d1   = $signed({~l1_s45[31], l1_s45[30:0]});
		d2   = $signed({~l2_s45[31], l2_s45[30:0]});
		ofx_sum = $signed({pax_s46[PA_W-1], pax_s46}) + (pbx_s46 >>> 16);
		ofy_sum = $signed({pay_s46[PA_W-1], pay_s46}) + (pby_s46 >>> 16);
		fx   = FIN_W'(px_s47) + FIN_W'(ox_s47);
		fy   = FIN_W'(py_s47) + FIN_W'(oy_s47);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (cor_s[spvg_pkg::CORDIC_STEPS-1].qd)
				2'd0: begin
					cx_s39 <= cor_s[spvg_pkg::CORDIC_STEPS-1].x;
					sy_s39 <= cor_s[spvg_pkg::CORDIC_STEPS-1].y;
				end
				2'd1: begin
					cx_s39 <= -cor_s[spvg_pkg::CORDIC_STEPS-1].y;
					sy_s39 <= cor_s[spvg_pkg::CORDIC_STEPS-1].x;
				end
				2'd2: begin
					cx_s39 <= -cor_s[spvg_pkg::CORDIC_STEPS-1].x;
					sy_s39 <= -cor_s[spvg_pkg::CORDIC_STEPS-1].y;
				end
				default: begin
					cx_s39 <= cor_s[spvg_pkg::CORDIC_STEPS-1].y;
					sy_s39 <= -cor_s[spvg_pkg::CORDIC_STEPS-1].x;
				end
			endcase
			rad_s39 <= cor_s[spvg_pkg::CORDIC_STEPS-1].radius;
			jit_s39 <= cor_s[spvg_pkg::CORDIC_STEPS-1].jit;

			prx_s40 <= $signed({1'b0, rad_s39}) * cx_s39;
			pry_s40 <= $signed({1'b0, rad_s39}) * sy_s39;
			jit_s40 <= jit_s39;

			rx_s41  <= sumx[PROD_W-1:30];
			ry_s41  <= sumy[PROD_W-1:30];
			jit_s41 <= jit_s40;

			px_s42  <= PX_W'(cfg.center_x) + PX_W'(rx_s41);
			py_s42  <= PX_W'(cfg.center_y) + PX_W'(ry_s41);
			jit_s42 <= jit_s41;

			seed_s43 <= {{4{hx[11]}}, hx, 16'h0000} + {{20{hy[11]}}, hy};
			px_s43   <= px_s42;
			py_s43   <= py_s42;
			jit_s43  <= jit_s42;

			l1_s44  <= seed_s43 * spvg_pkg::LCG_MUL + 32'd1;
			px_s44  <= px_s43;
			py_s44  <= py_s43;
			jit_s44 <= jit_s43;

			l2_s45  <= l1_s44 * spvg_pkg::LCG_MUL + 32'd1;
			l1_s45  <= l1_s44;
			px_s45  <= px_s44;
			py_s45  <= py_s44;
			jit_s45 <= jit_s44;

			pax_s46 <= t_q * $signed(d1[31:16]);
			pbx_s46 <= t_q * $signed({1'b0, d1[15:0]});
			pay_s46 <= t_q * $signed(d2[31:16]);
			pby_s46 <= t_q * $signed({1'b0, d2[15:0]});
			px_s46  <= px_s45;
			py_s46  <= py_s45;
			jit_s46 <= jit_s45;

			ox_s47 <= jit_s46 ? ofx_sum[28+OFF_W-1:28] : '0;
			oy_s47 <= jit_s46 ? ofy_sum[28+OFF_W-1:28] : '0;
			px_s47 <= px_s46;
			py_s47 <= py_s46;
		end
	end

	always_comb begin
		if (fx > SAT_HI) begin
			res.point_x = SAT_HI[31:0];
		end else if (fx < SAT_LO) begin
			res.point_x = SAT_LO[31:0];
		end else begin
			res.point_x = fx[31:0];
		end
		if (fy > SAT_HI) begin
			res.point_y = SAT_HI[31:0];
		end else if (fy < SAT_LO) begin
			res.point_y = SAT_LO[31:0];
		end else begin
			res.point_y = fy[31:0];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/star_polygon_vertex_generator.sv */
// Top level of the star polygon vertex generator.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                 Payload
// input     push / full               vertex (kind, index, jitter request)
// result    empty / pop               point (x, y, Q16.16, saturated)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is accepted per cycle while the request queue is not full, and one
// result leaves per cycle while pop is high and one is waiting. An accepted item
// passes the request queue, then 47 pipeline stages (7 for the index division,
// one for the phase, 30 CORDIC steps, 9 for scaling, hashing, LCG and offsets).
// The pipeline advances as a whole whenever the result queue has room, so a
// stall on the result side holds every stage; reset empties both queues and
// loads the default configuration. Configuration writes are always taken.
module star_polygon_vertex_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  spvg_pkg::vertex_t                  vertex,
	output logic                               empty,
	input  logic                               pop,
	output spvg_pkg::point_t                   point,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [spvg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data
);

	spvg_pkg::cfg_t cfg_q;
	spvg_pkg::job_t front_job;
	spvg_pkg::job_t queue_job;
	spvg_pkg::point_t back_res;
	logic queue_empty;
	logic job_take;
	logic res_valid;
	logic res_full;
	logic room;

	assign cfg_ready = 1'b1;

	// Register file; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_count    <= 11'd5;
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.outer_radius  <= 31'd65536;
			cfg_q.inner_radius  <= 31'd66;
			cfg_q.outer_angle   <= '0;
			cfg_q.inner_angle   <= '0;
			cfg_q.jitter_amount <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spvg_pkg::REG_SIDE_COUNT:    cfg_q.side_count    <= cfg_data[10:0];
				spvg_pkg::REG_CENTER_X:      cfg_q.center_x      <= cfg_data;
				spvg_pkg::REG_CENTER_Y:      cfg_q.center_y      <= cfg_data;
				spvg_pkg::REG_OUTER_RADIUS:  cfg_q.outer_radius  <= cfg_data[30:0];
				spvg_pkg::REG_INNER_RADIUS:  cfg_q.inner_radius  <= cfg_data[30:0];
				spvg_pkg::REG_OUTER_ANGLE:   cfg_q.outer_angle   <= cfg_data[15:0];
				spvg_pkg::REG_INNER_ANGLE:   cfg_q.inner_angle   <= cfg_data[15:0];
				spvg_pkg::REG_JITTER_AMOUNT: cfg_q.jitter_amount <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	spvg_front u_front (
		.vertex (vertex),
		.cfg    (cfg_q),
		.job    (front_job)
	);

	spvg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push && !full),
		.wr_data (front_job),
		.rd      (job_take),
		.rd_data (queue_job),
		.empty   (queue_empty),
		.full    (full)
	);

	// The pipeline may move when the result queue has a free slot or frees one now.
	assign room = !res_full || pop;

	spvg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (queue_job),
		.job_valid (!queue_empty),
		.job_take  (job_take),
		.room      (room),
		.res_valid (res_valid),
		.res       (back_res)
	);

	spvg_result_queue u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_valid),
		.wr_data (back_res),
		.rd      (pop),
		.rd_data (point),
		.empty   (empty),
		.full    (res_full)
	);

endmodule
`default_nettype wire

/* tb/sv/tb_star_polygon_vertex_generator.sv */
// Self-checking testbench of the star polygon vertex generator.
`timescale 1ns / 1ps
module tb_star_polygon_vertex_generator;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 64;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	spvg_pkg::vertex_t vertex = '0;
	logic      empty;
	logic      pop = 1'b0;
	spvg_pkg::point_t  point;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [spvg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Mirror of the block's configuration, loaded with its reset values.
	spvg_pkg::cfg_t star_cfg = '{side_count: 11'd5, center_x: 32'sd0, center_y: 32'sd0,
		outer_radius: 31'd65536, inner_radius: 31'd66, outer_angle: 16'd0,
		inner_angle: 16'd0, jitter_amount: 16'sd0};

	// Vertices predicted for accepted items, oldest first.
	spvg_pkg::point_t pending_points[$];
	int     error_count = 0;
	bit     idling = 1'b1;      // When clear, neither side inserts gaps.
	int     pop_hold = 0;       // Cycles the receiver still refuses results.
	int     quiet_cycles = 0;

	// Arctangent of 2^-i as a fraction of 2^32 of a turn.
	localparam longint ATAN_STEP[spvg_pkg::CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1};

	star_polygon_vertex_generator dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .vertex(vertex),
		.empty(empty), .pop(pop), .point(point),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Hash of one coordinate: the remainders truncate toward zero, as the block does.
	function automatic longint coord_hash(longint v);
		return ((v >>> 10) % 1024) + ((v >>> 6) % 64);
	endfunction

	// floor(t * d / 2^44), with d split into halves so nothing overflows.
	function automatic longint jitter_offset(longint t, longint d);
		longint dh, dl;
		dh = d >>> 16;
		dl = d - dh * 65536;
		return (t * dh + ((t * dl) >>> 16)) >>> 28;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return 32'(v);
	endfunction

	// Predicts the vertex that the block returns for one item.
	function automatic spvg_pkg::point_t predict_vertex(spvg_pkg::vertex_t v);
		longint unsigned n;
		logic [31:0] base, phase, r, seed, l1, l2;
		logic [1:0]  q;
		longint x, y, z, dx, dy, c, s, rad, rng, t, px, py;
		spvg_pkg::point_t p;
		n = star_cfg.side_count;
		if (n < 2)
			n = 2;
		if (n > spvg_pkg::MAX_SIDES)
			n = spvg_pkg::MAX_SIDES;
		base = (v.vertex_kind == spvg_pkg::KIND_INNER) ? star_cfg.inner_angle
			: star_cfg.outer_angle;
		rad = (v.vertex_kind == spvg_pkg::KIND_INNER) ? star_cfg.inner_radius
			: star_cfg.outer_radius;
		phase = (base << 16) + 32'((longint'(v.vertex_index) << 32) / n);
		// Reduce to the nearest quadrant, then rotate the residual angle.
		q = 2'((phase + 32'h2000_0000) >> 30);
		r = phase - {q, 30'b0};
		z = longint'($signed(r));
		x = 652032874;
		y = 0;
		for (int i = 0; i < spvg_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_STEP[i];
			end else begin
				x += dx; y -= dy; z += ATAN_STEP[i];
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		px = longint'(star_cfg.center_x) + ((rad * c + 64'sd536870912) >>> 30);
		py = longint'(star_cfg.center_y) + ((rad * s + 64'sd536870912) >>> 30);
		if (v.apply_jitter && star_cfg.jitter_amount != 0) begin
			seed = 32'(coord_hash(px) * 65536 + coord_hash(py));
			l1 = seed * 32'd69069 + 32'd1;
			l2 = l1 * 32'd69069 + 32'd1;
			rng = 2 * ((star_cfg.outer_radius > star_cfg.inner_radius) ?
				longint'(star_cfg.outer_radius) : longint'(star_cfg.inner_radius));
			t = longint'(star_cfg.jitter_amount) * rng;
			px += jitter_offset(t, longint'(l1) - 64'sd2147483648);
			py += jitter_offset(t, longint'(l2) - 64'sd2147483648);
		end
		p.point_x = clamp32(px);
		p.point_y = clamp32(py);
		return p;
	endfunction

	function automatic int draw_gap();
		return idling ? $urandom_range(0, 16) : 0;
	endfunction

	// Offers one item and returns at the edge that accepts it; push stays high.
	task automatic send_vertex(logic kind, logic [spvg_pkg::IDX_W-1:0] idx, logic jit);
		int gap;
		spvg_pkg::vertex_t v;
		gap = draw_gap();
		v.vertex_kind = kind;
		v.vertex_index = idx;
		v.apply_jitter = jit;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		vertex <= v;
		do @(posedge clk); while (full);
		pending_points.push_back(predict_vertex(v));
	endtask

	task automatic send_random_vertex();
		send_vertex(1'($urandom), 10'($urandom), 1'($urandom));
	endtask

	// Stops offering items and waits until every predicted vertex has arrived.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes one register; the caller makes sure the block is idle.
	task automatic write_reg(spvg_pkg::cfg_reg_t r, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			spvg_pkg::REG_SIDE_COUNT:    star_cfg.side_count = d[10:0];
			spvg_pkg::REG_CENTER_X:      star_cfg.center_x = d;
			spvg_pkg::REG_CENTER_Y:      star_cfg.center_y = d;
			spvg_pkg::REG_OUTER_RADIUS:  star_cfg.outer_radius = d[30:0];
			spvg_pkg::REG_INNER_RADIUS:  star_cfg.inner_radius = d[30:0];
			spvg_pkg::REG_OUTER_ANGLE:   star_cfg.outer_angle = d[15:0];
			spvg_pkg::REG_INNER_ANGLE:   star_cfg.inner_angle = d[15:0];
			default:                     star_cfg.jitter_amount = d[15:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A five-point star at reset: all outer points, an inner one, the highest
	// index, and jitter requests that a zero amount turns into the exact points.
	task automatic test_reset_defaults();
		for (int i = 0; i < 5; i++)
			send_vertex(1'b0, 10'(i), 1'b0);
		send_vertex(1'b1, 10'd0, 1'b0);
		send_vertex(1'b1, 10'd1023, 1'b1);
		send_vertex(1'b0, 10'd3, 1'b1);
		drain();
	endtask

	// Side counts below two act as two, above the maximum as the maximum, and
	// an index past the count wraps around the turn.
	task automatic test_side_count_limits();
		logic [10:0] counts[5] = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd3};
		foreach (counts[i]) begin
			write_reg(spvg_pkg::REG_SIDE_COUNT, 32'(counts[i]));
			send_vertex(1'b0, 10'd1, 1'b0);
			send_vertex(1'b1, 10'd1023, 1'b0);
			drain();
		end
	endtask

	// Extreme radii, centers, angles and jitter amounts drive the outputs into
	// saturation in both directions.
	task automatic test_jitter_and_saturation();
		write_reg(spvg_pkg::REG_OUTER_RADIUS, 32'h7FFF_FFFF);
		write_reg(spvg_pkg::REG_INNER_RADIUS, 32'h7FFF_FFFF);
		write_reg(spvg_pkg::REG_CENTER_X, 32'h7FFF_FFFF);
		write_reg(spvg_pkg::REG_CENTER_Y, 32'h8000_0000);
		write_reg(spvg_pkg::REG_OUTER_ANGLE, 32'd65535);
		write_reg(spvg_pkg::REG_INNER_ANGLE, 32'd32768);
		write_reg(spvg_pkg::REG_JITTER_AMOUNT, 32'h0000_7FFF);
		send_vertex(1'b0, 10'd0, 1'b1);
		send_vertex(1'b1, 10'd1, 1'b1);
		drain();
		write_reg(spvg_pkg::REG_JITTER_AMOUNT, 32'h0000_8000);
		write_reg(spvg_pkg::REG_CENTER_X, 32'h8000_0000);
		write_reg(spvg_pkg::REG_CENTER_Y, 32'h7FFF_FFFF);
		send_vertex(1'b0, 10'd2, 1'b1);
		send_vertex(1'b1, 10'd0, 1'b0);
		drain();
	endtask

	// Fresh random settings, then a run of random items; some phases run
	// without gaps on either side.
	task automatic test_random_phases(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			if ($urandom_range(0, 3) == 0)
				write_reg(spvg_pkg::REG_SIDE_COUNT, $urandom_range(0, 2047));
			else
				write_reg(spvg_pkg::REG_SIDE_COUNT, $urandom_range(2, 16));
			write_reg(spvg_pkg::REG_CENTER_X,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22));
			write_reg(spvg_pkg::REG_CENTER_Y, $urandom);
			write_reg(spvg_pkg::REG_OUTER_RADIUS,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 24));
			write_reg(spvg_pkg::REG_INNER_RADIUS,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
			write_reg(spvg_pkg::REG_OUTER_ANGLE, $urandom);
			write_reg(spvg_pkg::REG_INNER_ANGLE, $urandom);
			write_reg(spvg_pkg::REG_JITTER_AMOUNT,
				($urandom_range(0, 4) == 0) ? 0 : $urandom);
			idling = (p % 3 != 2);
			repeat (per_phase) send_random_vertex();
			drain();
		end
		idling = 1'b1;
	endtask

	// The receiver refuses results for a long stretch while items keep coming,
	// so the pipeline and both queues fill and the input stalls.
	task automatic test_backpressure();
		idling = 1'b0;
		pop_hold = 300;
		repeat (80) send_random_vertex();
		idling = 1'b1;
		drain();
	endtask

	// Receiver: draws a wait per result, honors the long hold-off, and checks
	// each accepted result against the oldest predicted vertex.
	initial begin
		int gap;
		spvg_pkg::point_t want;
		gap = 0;
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else if (gap > 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_points.size() == 0) begin
					$error("result with no vertex expected: x=%0d y=%0d",
						point.point_x, point.point_y);
					error_count++;
				end else begin
					want = pending_points.pop_front();
					if (point.point_x !== want.point_x) begin
						$error("point_x expected %0d actual %0d", want.point_x, point.point_x);
						error_count++;
					end
					if (point.point_y !== want.point_y) begin
						$error("point_y expected %0d actual %0d", want.point_y, point.point_y);
						error_count++;
					end
				end
				gap = draw_gap();
			end
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_star_polygon_vertex_generator NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_side_count_limits();
		test_jitter_and_saturation();
		test_random_phases(7, 90);
		test_backpressure();
		if (error_count == 0)
			$display("tb_star_polygon_vertex_generator OK");
		else
			$display("tb_star_polygon_vertex_generator NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/spvg_pkg.sv
hw/rtl/spvg_front.sv
hw/rtl/spvg_queue.sv
hw/rtl/spvg_result_queue.sv
hw/rtl/spvg_back.sv
hw/rtl/star_polygon_vertex_generator.sv
tb/sv/tb_star_polygon_vertex_generator.sv
